### design/ssv_pkg.sv
`default_nettype none
package ssv_pkg;
    localparam int POS_WIDTH_DEF = 24;
    localparam int STOP_WIDTH    = 24;
    localparam int SPEED_WIDTH   = 16;
    localparam int VEL_WIDTH     = 17;
    localparam int QUO_BITS      = 16;
    localparam int STOP_SQ_WIDTH = 2 * STOP_WIDTH;
    localparam int AXES          = 3;
    localparam logic [STOP_WIDTH-1:0] STOP_RESET = 24'd8448;
endpackage
`default_nettype wire

### design/ssv_if.sv
`default_nettype none
interface ssv_in_if #(
    parameter int POS_WIDTH = ssv_pkg::POS_WIDTH_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [POS_WIDTH-1:0]        cur_x;
    logic signed [POS_WIDTH-1:0]        cur_y;
    logic signed [POS_WIDTH-1:0]        cur_z;
    logic signed [POS_WIDTH-1:0]        tgt_x;
    logic signed [POS_WIDTH-1:0]        tgt_y;
    logic signed [POS_WIDTH-1:0]        tgt_z;
    logic [ssv_pkg::SPEED_WIDTH-1:0]    speed;

    modport source (output valid, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, speed,
                    input ready);
    modport sink (input valid, cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, speed,
                  output ready);
endinterface

interface ssv_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ssv_pkg::VEL_WIDTH-1:0]   vel_x;
    logic signed [ssv_pkg::VEL_WIDTH-1:0]   vel_y;
    logic signed [ssv_pkg::VEL_WIDTH-1:0]   vel_z;
    logic                                   stopped;

    modport source (output valid, vel_x, vel_y, vel_z, stopped, input ready);
    modport sink (input valid, vel_x, vel_y, vel_z, stopped, output ready);
endinterface
`default_nettype wire

### design/steering_seek_velocity.sv
`default_nettype none
// channel   | dir | beat contents
// i_in      | in  | cur_x/y/z, tgt_x/y/z (POS_WIDTH, signed), speed (16)
// o_out     | out | vel_x/y/z (17, signed Q8.8), stopped
// i_cfg_*   | in  | stop_distance (24, Q16.8), write only
//
// one beat per cycle while the output is taken; 3 prep stages, one square root
// stage per root bit, 16 divider stages per lane, output register
// reset clears the valid line and loads stop_distance with 33.0
// a result held at the output freezes the whole pipeline until taken
module steering_seek_velocity #(
    parameter int POS_WIDTH = ssv_pkg::POS_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [ssv_pkg::STOP_WIDTH-1:0]   i_cfg_wdata,
    ssv_in_if.sink                           i_in,
    ssv_out_if.source                        o_out
);
    localparam int SW  = 2 * POS_WIDTH + 4;
    localparam int RW  = POS_WIDTH + 1;
    localparam int NW  = POS_WIDTH + ssv_pkg::SPEED_WIDTH + 1;
    localparam int QB  = ssv_pkg::QUO_BITS;
    localparam int AX  = ssv_pkg::AXES;
    localparam int VW  = ssv_pkg::VEL_WIDTH;
    localparam int PRE = 3;
    localparam int SBW = AX * NW + AX + 1;

    logic [ssv_pkg::STOP_SQ_WIDTH-1:0] r_stop_sq;
    logic                              w_en;
    logic [PRE-1:0]                    r_v_pre;
    logic [RW-1:0]                     r_v_sq;
    logic [QB-1:0]                     r_v_div;
    logic                              r_out_valid;
    logic [POS_WIDTH-1:0]              w_cur [AX];
    logic [POS_WIDTH-1:0]              w_tgt [AX];
    logic [SW-1:0]                     w_sum;
    logic [NW-1:0]                     w_prod [AX];
    logic [AX-1:0]                     w_neg;
    logic                              w_stop;
    logic [SBW-1:0]                    r_sb [RW];
    logic [SBW-1:0]                    w_sb_in;
    logic [SBW-1:0]                    w_sb_out;
    logic [RW-1:0]                     w_root;
    logic [AX:0]                       r_flag [QB];
    logic [QB-1:0]                     w_quo [AX];
    logic [VW-1:0]                     r_vel [AX];
    logic                              r_stopped;

    // stop distance kept squared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_sq <= ssv_pkg::STOP_SQ_WIDTH'(ssv_pkg::STOP_RESET)
                         * ssv_pkg::STOP_SQ_WIDTH'(ssv_pkg::STOP_RESET);
        end else if (i_cfg_we) begin
            r_stop_sq <= ssv_pkg::STOP_SQ_WIDTH'(i_cfg_wdata)
                         * ssv_pkg::STOP_SQ_WIDTH'(i_cfg_wdata);
        end
    end

    // pipeline advances unless the output holds an untaken beat
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_pre     <= '0;
            r_v_sq      <= '0;
            r_v_div     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v_pre     <= {r_v_pre[PRE-2:0], i_in.valid};
            r_v_sq      <= {r_v_sq[RW-2:0], r_v_pre[PRE-1]};
            r_v_div     <= {r_v_div[QB-2:0], r_v_sq[RW-1]};
            r_out_valid <= r_v_div[QB-1];
        end
    end

    assign w_cur[0] = i_in.cur_x;
    assign w_cur[1] = i_in.cur_y;
    assign w_cur[2] = i_in.cur_z;
    assign w_tgt[0] = i_in.tgt_x;
    assign w_tgt[1] = i_in.tgt_y;
    assign w_tgt[2] = i_in.tgt_z;

    ssv_prep #(.POS_WIDTH(POS_WIDTH)) u_prep (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_cur     (w_cur),
        .i_tgt     (w_tgt),
        .i_speed   (i_in.speed),
        .i_stop_sq (r_stop_sq),
        .o_sum     (w_sum),
        .o_prod    (w_prod),
        .o_neg     (w_neg),
        .o_stop    (w_stop)
    );

    ssv_sqrt #(.POS_WIDTH(POS_WIDTH)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (w_sum),
        .o_root (w_root)
    );

    // products, signs and stop ride alongside the root
    assign w_sb_in = {w_prod[2], w_prod[1], w_prod[0], w_neg, w_stop};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= w_sb_in;
            for (int s = 1; s < RW; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
        end
    end

    assign w_sb_out = r_sb[RW-1];

    // one divider lane per axis
    for (genvar a = 0; a < AX; a++) begin : g_lane
        ssv_div_lane #(.POS_WIDTH(POS_WIDTH)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_sb_out[AX + 1 + a*NW +: NW]),
            .i_den (w_root),
            .o_quo (w_quo[a])
        );
    end

    // signs and stop ride alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flag[0] <= w_sb_out[AX:0];
            for (int s = 1; s < QB; s++) begin
                r_flag[s] <= r_flag[s-1];
            end
        end
    end

    // merge: apply sign, zero when stopped
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stopped <= r_flag[QB-1][0];
            for (int a = 0; a < AX; a++) begin
                if (r_flag[QB-1][0]) begin
                    r_vel[a] <= '0;
                end else if (r_flag[QB-1][a+1]) begin
                    r_vel[a] <= ~VW'(w_quo[a]) + VW'(1);
                end else begin
                    r_vel[a] <= VW'(w_quo[a]);
                end
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.vel_x   = r_vel[0];
    assign o_out.vel_y   = r_vel[1];
    assign o_out.vel_z   = r_vel[2];
    assign o_out.stopped = r_stopped;
endmodule
`default_nettype wire

### design/ssv_prep.sv
`default_nettype none
module ssv_prep #(
    parameter int POS_WIDTH = ssv_pkg::POS_WIDTH_DEF,
    localparam int MW = POS_WIDTH + 1,
    localparam int SW = 2 * POS_WIDTH + 4,
    localparam int NW = POS_WIDTH + ssv_pkg::SPEED_WIDTH + 1,
    localparam int CW = (SW > ssv_pkg::STOP_SQ_WIDTH) ? SW : ssv_pkg::STOP_SQ_WIDTH
) (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire  [POS_WIDTH-1:0]                 i_cur [ssv_pkg::AXES],
    input  wire  [POS_WIDTH-1:0]                 i_tgt [ssv_pkg::AXES],
    input  wire  [ssv_pkg::SPEED_WIDTH-1:0]      i_speed,
    input  wire  [ssv_pkg::STOP_SQ_WIDTH-1:0]    i_stop_sq,
    output logic [SW-1:0]                        o_sum,
    output logic [NW-1:0]                        o_prod [ssv_pkg::AXES],
    output logic [ssv_pkg::AXES-1:0]             o_neg,
    output logic                                 o_stop
);
    logic [MW-1:0]                    r_mag [ssv_pkg::AXES];
    logic [ssv_pkg::AXES-1:0]         r_neg_a;
    logic [ssv_pkg::SPEED_WIDTH-1:0]  r_speed;
    logic [2*MW-1:0]                  r_sq [ssv_pkg::AXES];
    logic [NW-1:0]                    r_prod_b [ssv_pkg::AXES];
    logic [ssv_pkg::AXES-1:0]         r_neg_b;
    logic [SW-1:0]                    r_sum;
    logic [NW-1:0]                    r_prod_c [ssv_pkg::AXES];
    logic [ssv_pkg::AXES-1:0]         r_neg_c;
    logic                             r_stop;
    logic [MW-1:0]                    n_diff [ssv_pkg::AXES];
    logic [SW-1:0]                    n_sum;

    // per-axis offset
    always_comb begin
        for (int a = 0; a < ssv_pkg::AXES; a++) begin
            n_diff[a] = {i_tgt[a][POS_WIDTH-1], i_tgt[a]} - {i_cur[a][POS_WIDTH-1], i_cur[a]};
        end
        n_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    // magnitude, then squares and speed products, then sum and stop test
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < ssv_pkg::AXES; a++) begin
                r_neg_a[a] <= n_diff[a][MW-1];
                r_mag[a]   <= n_diff[a][MW-1] ? (~n_diff[a] + MW'(1)) : n_diff[a];
                r_sq[a]    <= (2*MW)'(r_mag[a]) * (2*MW)'(r_mag[a]);
                r_prod_b[a] <= NW'(r_mag[a]) * NW'(r_speed);
                r_prod_c[a] <= r_prod_b[a];
            end
            r_speed <= i_speed;
            r_neg_b <= r_neg_a;
            r_neg_c <= r_neg_b;
            r_sum   <= n_sum;
            r_stop  <= CW'(n_sum) <= CW'(i_stop_sq);
        end
    end

    assign o_sum  = r_sum;
    assign o_prod = r_prod_c;
    assign o_neg  = r_neg_c;
    assign o_stop = r_stop;
endmodule
`default_nettype wire

### design/ssv_sqrt.sv
`default_nettype none
module ssv_sqrt #(
    parameter int POS_WIDTH = ssv_pkg::POS_WIDTH_DEF,
    localparam int SW = 2 * POS_WIDTH + 4,
    localparam int RW = POS_WIDTH + 1
) (
    input  wire           i_clk,
    input  wire           i_en,
    input  wire  [SW-1:0] i_x,
    output logic [RW-1:0] o_root
);
    logic [SW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];

    // one root bit per stage, from the top bit down
    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int B = RW - 1 - s;
        logic [SW-1:0] w_rem_in;
        logic [RW-1:0] w_root_in;
        logic [SW-1:0] w_trial;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_x;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign w_trial = (SW'(w_root_in) << (B + 1)) | (SW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_in >= w_trial) begin
                    r_rem[s]  <= w_rem_in - w_trial;
                    r_root[s] <= w_root_in | (RW'(1) << B);
                end else begin
                    r_rem[s]  <= w_rem_in;
                    r_root[s] <= w_root_in;
                end
            end
        end
    end

    assign o_root = r_root[RW-1];
endmodule
`default_nettype wire

### design/ssv_div_lane.sv
`default_nettype none
module ssv_div_lane #(
    parameter int POS_WIDTH = ssv_pkg::POS_WIDTH_DEF,
    localparam int RW = POS_WIDTH + 1,
    localparam int NW = POS_WIDTH + ssv_pkg::SPEED_WIDTH + 1,
    localparam int QB = ssv_pkg::QUO_BITS
) (
    input  wire           i_clk,
    input  wire           i_en,
    input  wire  [NW-1:0] i_num,
    input  wire  [RW-1:0] i_den,
    output logic [QB-1:0] o_quo
);
    logic [NW-1:0] r_rem [QB];
    logic [RW-1:0] r_den [QB];
    logic [QB-1:0] r_quo [QB];

    // restoring division, one quotient bit per stage
    for (genvar s = 0; s < QB; s++) begin : g_stage
        localparam int K = QB - 1 - s;
        logic [NW-1:0] w_rem_in;
        logic [RW-1:0] w_den_in;
        logic [QB-1:0] w_quo_in;
        logic [NW-1:0] w_sub;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        assign w_sub = NW'(w_den_in) << K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= w_den_in;
                if (w_rem_in >= w_sub) begin
                    r_rem[s] <= w_rem_in - w_sub;
                    r_quo[s] <= w_quo_in | (QB'(1) << K);
                end else begin
                    r_rem[s] <= w_rem_in;
                    r_quo[s] <= w_quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QB-1];
endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
    localparam int PW      = ssv_pkg::POS_WIDTH_DEF;
    localparam int LATENCY = PW + 21;

    typedef struct {
        logic signed [PW-1:0]                   cur_x, cur_y, cur_z;
        logic signed [PW-1:0]                   tgt_x, tgt_y, tgt_z;
        logic [ssv_pkg::SPEED_WIDTH-1:0]        speed;
    } seek_req_t;

    typedef struct {
        logic signed [ssv_pkg::VEL_WIDTH-1:0]   vel_x, vel_y, vel_z;
        logic                                   stopped;
    } seek_vel_t;

    // seek velocity predictor and in-order result check
    class seek_ledger;
        logic [ssv_pkg::STOP_WIDTH-1:0] stop_dist;
        seek_vel_t                      pending_vel[$];
        int                             mismatches;

        function new();
            stop_dist  = ssv_pkg::STOP_RESET;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $time, msg);
            mismatches++;
        endtask

        function void note_request(seek_req_t r);
            longint              off[3];
            longint unsigned     mag[3];
            longint unsigned     len_sq, stop_sq, root_len, cand, quo;
            logic signed [ssv_pkg::VEL_WIDTH-1:0] vel[3];
            seek_vel_t           res;
            off[0] = longint'(r.tgt_x) - longint'(r.cur_x);
            off[1] = longint'(r.tgt_y) - longint'(r.cur_y);
            off[2] = longint'(r.tgt_z) - longint'(r.cur_z);
            len_sq = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = (off[i] < 0) ? -off[i] : off[i];
                len_sq += mag[i] * mag[i];
            end
            stop_sq = longint'(stop_dist) * longint'(stop_dist);
            if (len_sq <= stop_sq) begin
                res = '{0, 0, 0, 1'b1};
            end else begin
                // bitwise floor square root
                root_len = 0;
                for (int b = 26; b >= 0; b--) begin
                    cand = root_len | (64'd1 << b);
                    if (cand * cand <= len_sq) root_len = cand;
                end
                for (int i = 0; i < 3; i++) begin
                    quo = (mag[i] * r.speed) / root_len;
                    if (off[i] < 0) quo = -quo;
                    vel[i] = quo[ssv_pkg::VEL_WIDTH-1:0];
                end
                res = '{vel[0], vel[1], vel[2], 1'b0};
            end
            pending_vel.push_back(res);
        endfunction

        task check_result(seek_vel_t got);
            seek_vel_t want;
            if (pending_vel.size() == 0) begin
                report("result beat with nothing pending");
                return;
            end
            want = pending_vel.pop_front();
            if (got.vel_x !== want.vel_x)
                report($sformatf("vel_x %0d want %0d", got.vel_x, want.vel_x));
            if (got.vel_y !== want.vel_y)
                report($sformatf("vel_y %0d want %0d", got.vel_y, want.vel_y));
            if (got.vel_z !== want.vel_z)
                report($sformatf("vel_z %0d want %0d", got.vel_z, want.vel_z));
            if (got.stopped !== want.stopped)
                report($sformatf("stopped %0b want %0b", got.stopped, want.stopped));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ssv_pkg::STOP_WIDTH-1:0] i_cfg_wdata;

    ssv_in_if #(.POS_WIDTH(PW)) in_if();
    ssv_out_if                  out_if();

    steering_seek_velocity #(.POS_WIDTH(PW)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    seek_ledger ledger = new();
    bit         no_idle;
    bit         hold_req;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // limit
    initial begin
        #(12 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            ledger.check_result('{out_if.vel_x, out_if.vel_y, out_if.vel_z, out_if.stopped});
    end

    // receiver ready with random stalls and one long hold-off
    initial begin
        int gap;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
        end
    end

    task write_stop(logic [ssv_pkg::STOP_WIDTH-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.stop_dist = v;
    endtask

    task send_request(seek_req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cur_x <= r.cur_x;
        in_if.cur_y <= r.cur_y;
        in_if.cur_z <= r.cur_z;
        in_if.tgt_x <= r.tgt_x;
        in_if.tgt_y <= r.tgt_y;
        in_if.tgt_z <= r.tgt_z;
        in_if.speed <= r.speed;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        ledger.note_request(r);
    endtask

    // drain pipeline before touching the register
    task wait_drained();
        while (ledger.pending_vel.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic signed [PW-1:0] rand_pos();
        return PW'($urandom());
    endfunction

    // offset target from current along a random direction
    function automatic seek_req_t near_request(int span);
        seek_req_t r;
        r.cur_x = PW'($signed($urandom_range(0, 2**22)) - 2**21);
        r.cur_y = PW'($signed($urandom_range(0, 2**22)) - 2**21);
        r.cur_z = PW'($signed($urandom_range(0, 2**22)) - 2**21);
        r.tgt_x = PW'(r.cur_x + $signed($urandom_range(0, 2 * span)) - span);
        r.tgt_y = PW'(r.cur_y + $signed($urandom_range(0, 2 * span)) - span);
        r.tgt_z = PW'(r.cur_z + $signed($urandom_range(0, 2 * span)) - span);
        r.speed = ssv_pkg::SPEED_WIDTH'($urandom());
        return r;
    endfunction

    function automatic seek_req_t random_request();
        seek_req_t r;
        int        sd;
        sd = int'(ledger.stop_dist);
        case ($urandom_range(0, 5))
            0: r = '{rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                     rand_pos(), 16'($urandom())};
            1: r = near_request(64);
            2: r = near_request(4096);
            3: r = near_request(2**20);
            default: begin
                // single axis right around the stop distance
                r = near_request(0);
                if (sd < 2**21)
                    r.tgt_y = PW'(r.cur_y + sd + $signed($urandom_range(0, 2)) - 1);
            end
        endcase
        case ($urandom_range(0, 7))
            0: r.speed = 16'h0000;
            1: r.speed = 16'hFFFF;
            default: ;
        endcase
        return r;
    endfunction

    logic [ssv_pkg::STOP_WIDTH-1:0] stop_plan[4];

    initial begin
        seek_req_t r;
        in_if.valid = 1'b0;
        in_if.cur_x = '0; in_if.cur_y = '0; in_if.cur_z = '0;
        in_if.tgt_x = '0; in_if.tgt_y = '0; in_if.tgt_z = '0;
        in_if.speed = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats at reset stop distance
        send_request('{0, 0, 0, 0, 0, 0, 16'hFFFF});                       // same position
        send_request('{0, 0, 0, 8448, 0, 0, 16'h0100});                    // exactly at stop
        send_request('{0, 0, 0, 8449, 0, 0, 16'h0100});                    // just past stop
        send_request('{0, 0, 0, 0, -8449, 0, 16'hFFFF});
        send_request('{0, 0, 0, 0, 0, 100000, 16'h0000});                  // zero speed
        send_request('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                       24'sh800000, 24'sh800000, 24'sh800000, 16'hFFFF});   // extreme offsets
        send_request('{24'sh800000, 24'sh800000, 24'sh800000,
                       24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF});
        send_request('{24'sh800000, 0, 24'sh7FFFFF, 24'sh7FFFFF, 0, 24'sh800000, 16'h0001});
        send_request('{0, 0, 0, 30000, -40000, 12345, 16'h8000});
        send_request('{5, -7, 9, -5, 7, -9, 16'hFFFF});
        send_request('{-1000000, 2000000, 0, 1000000, -2000000, 3, 16'h1234});

        // several stop distances including both extremes
        stop_plan[0] = 24'd8448;
        stop_plan[1] = 24'd0;
        stop_plan[2] = 24'hFFFFFF;
        stop_plan[3] = ssv_pkg::STOP_WIDTH'($urandom_range(1, 2**20));
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                in_if.valid <= 1'b0;
                wait_drained();
                write_stop(stop_plan[ph]);
                send_request('{0, 0, 0, 0, 0, 0, 16'hFFFF});
                send_request('{0, 0, 0, 0, 0, 0, 16'h0000});
            end
            for (int n = 0; n < 410; n++) begin
                no_idle = (n >= 100 && n < 160);
                if (ph == 1 && n == 200) hold_req = 1'b1;
                send_request(random_request());
            end
            no_idle = 1'b0;
        end
        in_if.valid <= 1'b0;

        wait_drained();
        if (ledger.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### files.f
design/ssv_pkg.sv
design/ssv_if.sv
design/ssv_prep.sv
design/ssv_sqrt.sv
design/ssv_div_lane.sv
design/steering_seek_velocity.sv
tb/tb_top.sv
